/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with asynchronous active-low reset disable.
`define CCLP_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error(msg);

// Implication that holds whenever the master side shows a valid beat.
`define CCLP_ASSERT_OUT(lbl, clk, rstn, vld, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) ((vld) |-> (prop))) \
		else $error(msg);

`endif

/* hw/rtl/cclp_pkg.sv */
// Types, character constants and helpers of the caret command-line parser.
package cclp_pkg;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_DEL   = 8'h7F;
	localparam logic [7:0] CH_BS    = 8'h08;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_F     = 8'h46;
	localparam logic [7:0] CH_S     = 8'h53;
	localparam logic [7:0] CH_B     = 8'h42;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_R     = 8'h52;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [15:0] PIN_RESET = 16'd1234;

	localparam int OUT_DATA_W = 40;

	typedef enum logic [3:0] {
		RSP_NONE    = 4'd0,
		RSP_PRESENT = 4'd1,
		RSP_FAST    = 4'd2,
		RSP_SLOW    = 4'd3,
		RSP_DENIED  = 4'd4,
		RSP_FWD     = 4'd5,
		RSP_BACK    = 4'd6,
		RSP_LEFT    = 4'd7,
		RSP_RIGHT   = 4'd8,
		RSP_UNKNOWN = 4'd9
	} rsp_t;

	typedef struct packed {
		logic [7:0]  echo_byte;
		logic        forward_valid;
		logic [7:0]  forward_byte;
		rsp_t        response_code;
		logic [15:0] duration;
		logic        baud_fast;
	} result_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	// Decimal accumulate, wrapping at 16 bits. The low nibble of an ASCII digit is its value.
	function automatic logic [15:0] mul10_add(input logic [15:0] a, input logic [7:0] d);
		logic [15:0] t;
		t = {a[12:0], 3'b000} + {a[14:0], 1'b0} + {12'h000, d[3:0]};
		return t;
	endfunction

endpackage

/* hw/rtl/caret_command_line_parser_top.sv */
// Top level of the caret command-line parser: input register, parser and result register.
//
// Usage: terminal bytes enter one per beat on the s_axis channel (tdata[7:0]).
// Every beat yields exactly one result beat on the m_axis channel, in order.
// A '^' in idle mode opens a command; a CR or LF closes it and the result
// beat of that byte carries the response code and, for drive commands, the
// duration. Plain text is forwarded; backspace and DEL are swallowed.
// The user must write the PIN through cfg_we/cfg_wdata only while no beat is in
// flight; the block itself does not enforce this. An accepted beat waits in the
// input register, passes the combinational parse step and is loaded into the
// result register once that register is free. Throughput: one beat per cycle
// while the receiver does not stall. When the receiver stalls, the result
// register holds its beat, the parse step waits, and the input register still
// takes one more beat, if it was empty, before s_axis_tready drops.
// Reset empties both registers, returns the parser to idle with an empty
// command, selects the fast rate and loads the PIN 1234.
module caret_command_line_parser_top import cclp_pkg::*; #(
	parameter int CMD_LEN = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [7:0]            s_axis_tdata,  // [7:0] rx_byte
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// [7:0] echo_byte, [8] forward_valid, [16:9] forward_byte, [20:17] response_code,
	// [36:21] duration, [37] baud_fast, [39:38] zero
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_wdata
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;
	result_t     res_s2;
	result_t     res;
	logic        advance;
	logic [15:0] pin_code_q;

	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pin_code_q <= PIN_RESET;
		end else if (cfg_we) begin
			pin_code_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	cclp_parse #(
		.CMD_LEN(CMD_LEN)
	) u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (advance),
		.rx_byte (byte_s1),
		.pin_code(pin_code_q),
		.result  (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || m_axis_tready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {2'b00, res_s2.baud_fast, res_s2.duration, res_s2.response_code,
	                        res_s2.forward_byte, res_s2.forward_valid, res_s2.echo_byte};

endmodule

/* hw/rtl/cclp_parse.sv */
// Parser state registers and the one-byte update step of the command line.
module cclp_parse import cclp_pkg::*; #(
	parameter int CMD_LEN = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          rx_byte,
	input  logic [15:0]         pin_code,
	output result_t             result
);

	localparam int CW = $clog2(CMD_LEN);
	localparam logic [CW-1:0] COUNT_MAX = CW'(CMD_LEN - 1);

	typedef enum logic [2:0] {
		MODE_IDLE  = 3'b001,
		MODE_WAIT  = 3'b010,
		MODE_BUILD = 3'b100
	} mode_t;

	typedef enum logic [2:0] {
		PH_FIRST  = 3'b001,
		PH_SECOND = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	mode_t          mode_q, mode_d;
	logic [CW-1:0]  count_q, count_d;
	logic [7:0]     first_q, first_d;
	phase_t         phase_q, phase_d;
	logic [15:0]    pin_acc_q, pin_acc_d;
	logic [7:0]     letter_q, letter_d;
	logic [15:0]    dur_acc_q, dur_acc_d;
	logic           fast_q, fast_d;

	// Result of storing the current byte as a command character.
	logic [7:0]     st_first;
	phase_t         st_phase;
	logic [15:0]    st_pin;
	logic [7:0]     st_letter;
	logic [15:0]    st_dur;
	logic           eol;

	always_comb begin
		st_first  = (count_q == '0) ? rx_byte : first_q;
		st_phase  = phase_q;
		st_pin    = pin_acc_q;
		st_letter = letter_q;
		st_dur    = dur_acc_q;
		if (is_digit(st_first)) begin
			unique case (phase_q)
				PH_FIRST: begin
					if (is_digit(rx_byte)) begin
						st_pin = mul10_add(pin_acc_q, rx_byte);
					end else begin
						st_letter = rx_byte;
						st_phase  = PH_SECOND;
					end
				end
				PH_SECOND: begin
					if (is_digit(rx_byte)) begin
						st_dur = mul10_add(dur_acc_q, rx_byte);
					end else begin
						st_phase = PH_DONE;
					end
				end
				PH_DONE: ;
				default: ;
			endcase
		end
	end

	assign eol = (rx_byte == CH_CR) || (rx_byte == CH_LF);

	always_comb begin
		mode_d    = mode_q;
		count_d   = count_q;
		first_d   = first_q;
		phase_d   = phase_q;
		pin_acc_d = pin_acc_q;
		letter_d  = letter_q;
		dur_acc_d = dur_acc_q;
		fast_d    = fast_q;

		result.echo_byte     = rx_byte;
		result.forward_valid = 1'b0;
		result.forward_byte  = 8'h00;
		result.response_code = RSP_NONE;
		result.duration      = 16'h0000;

		unique case (mode_q)
			MODE_IDLE: begin
				if (rx_byte == CH_CARET) begin
					mode_d = MODE_WAIT;
				end else if ((rx_byte != CH_DEL) && (rx_byte != CH_BS)) begin
					result.forward_valid = 1'b1;
					result.forward_byte  = rx_byte;
				end
			end
			MODE_WAIT: begin
				if (rx_byte == CH_CARET) begin
					result.response_code = RSP_PRESENT;
					mode_d = MODE_IDLE;
				end else if (eol) begin
					mode_d = MODE_IDLE;
				end else begin
					count_d   = count_q + 1'b1;
					first_d   = st_first;
					phase_d   = st_phase;
					pin_acc_d = st_pin;
					letter_d  = st_letter;
					dur_acc_d = st_dur;
					mode_d    = MODE_BUILD;
				end
			end
			MODE_BUILD: begin
				if (eol) begin
					mode_d = MODE_IDLE;
					if ((count_q == CW'(1)) && (first_q == CH_F)) begin
						fast_d = 1'b1;
						result.response_code = RSP_FAST;
					end else if ((count_q == CW'(1)) && (first_q == CH_S)) begin
						fast_d = 1'b0;
						result.response_code = RSP_SLOW;
					end else if (is_digit(first_q)) begin
						if (pin_acc_q != pin_code) begin
							result.response_code = RSP_DENIED;
						end else begin
							case (letter_q)
								CH_F:    result.response_code = RSP_FWD;
								CH_B:    result.response_code = RSP_BACK;
								CH_L:    result.response_code = RSP_LEFT;
								CH_R:    result.response_code = RSP_RIGHT;
								default: result.response_code = RSP_UNKNOWN;
							endcase
							if (result.response_code != RSP_UNKNOWN) begin
								result.duration = dur_acc_q;
							end
						end
					end
				end else if (count_q < COUNT_MAX) begin
					count_d   = count_q + 1'b1;
					first_d   = st_first;
					phase_d   = st_phase;
					pin_acc_d = st_pin;
					letter_d  = st_letter;
					dur_acc_d = st_dur;
				end
			end
			default: begin
				mode_d = MODE_IDLE;
			end
		endcase

		// Every return to idle leaves a cleared command buffer behind.
		if (mode_d == MODE_IDLE) begin
			count_d   = '0;
			first_d   = 8'h00;
			phase_d   = PH_FIRST;
			pin_acc_d = 16'h0000;
			letter_d  = 8'h00;
			dur_acc_d = 16'h0000;
		end

		result.baud_fast = fast_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_IDLE;
			count_q   <= '0;
			first_q   <= 8'h00;
			phase_q   <= PH_FIRST;
			pin_acc_q <= 16'h0000;
			letter_q  <= 8'h00;
			dur_acc_q <= 16'h0000;
			fast_q    <= 1'b1;
		end else if (step) begin
			mode_q    <= mode_d;
			count_q   <= count_d;
			first_q   <= first_d;
			phase_q   <= phase_d;
			pin_acc_q <= pin_acc_d;
			letter_q  <= letter_d;
			dur_acc_q <= dur_acc_d;
			fast_q    <= fast_d;
		end
	end

endmodule

/* hw/rtl/cclp_checker.sv */
// Port-level checker of the caret command-line parser, bound to the top level.
`include "assert_macros.svh"

module cclp_checker import cclp_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata
);

	logic       fwd_v;
	logic [3:0] code;
	logic       drive_code;

	assign fwd_v      = m_axis_tdata[8];
	assign code       = m_axis_tdata[20:17];
	assign drive_code = (code == RSP_FWD) || (code == RSP_BACK) ||
	                    (code == RSP_LEFT) || (code == RSP_RIGHT);

	// A forwarded byte is the echoed byte; otherwise the forward field is zero.
	`CCLP_ASSERT_OUT(a_fwd_match, clk, arst_n, m_axis_tvalid,
		(fwd_v ? (m_axis_tdata[16:9] == m_axis_tdata[7:0]) : (m_axis_tdata[16:9] == 8'h00)),
		"forward byte does not match echo")
	// A response is only given when nothing is forwarded.
	`CCLP_ASSERT_OUT(a_rsp_no_fwd, clk, arst_n, m_axis_tvalid,
		(code == RSP_NONE) || !fwd_v, "response together with a forwarded byte")
	// Duration is reported only with the drive responses.
	`CCLP_ASSERT_OUT(a_dur_zero, clk, arst_n, m_axis_tvalid,
		drive_code || (m_axis_tdata[36:21] == 16'h0000), "duration outside a drive response")
	// The rate flag follows a rate response in the same beat.
	`CCLP_ASSERT_OUT(a_baud_rsp, clk, arst_n, m_axis_tvalid,
		((code != RSP_FAST) || m_axis_tdata[37]) && ((code != RSP_SLOW) || !m_axis_tdata[37]),
		"rate flag disagrees with rate response")
	`CCLP_ASSERT(a_out_hold, clk, arst_n,
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)),
		"result beat changed while stalled")

endmodule

bind caret_command_line_parser_top cclp_checker u_cclp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

/* tb/tb_caret_command_line_parser_top.sv */
// Self-checking testbench for the caret command-line parser: directed and random byte streams.
module tb_caret_command_line_parser_top import cclp_pkg::*; ();

	localparam int CMD_LEN = 32;

	typedef enum logic [1:0] {PM_IDLE, PM_WAIT, PM_BUILD} pmode_t;
	typedef enum logic [1:0] {FP_PIN, FP_DUR, FP_END} fphase_t;

	typedef struct packed {
		logic [7:0]  echo;
		logic        fwd_v;
		logic [7:0]  fwd_b;
		rsp_t        code;
		logic [15:0] dur;
		logic        baud;
	} reply_t;

	typedef struct packed {
		logic       typed;
		rsp_t       code;
		logic [7:0] rx;
	} drow_t;

	// Directed stream; the response code is typed in on the rows where it is obvious.
	localparam drow_t DIRECTED [0:26] = '{
		'{1'b1, RSP_NONE,    8'h00},
		'{1'b1, RSP_NONE,    8'hFF},
		'{1'b0, RSP_NONE,    CH_BS},
		'{1'b0, RSP_NONE,    CH_DEL},
		'{1'b1, RSP_NONE,    CH_CR},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b1, RSP_PRESENT, CH_CARET},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b0, RSP_NONE,    CH_S},
		'{1'b1, RSP_SLOW,    CH_LF},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b0, RSP_NONE,    CH_F},
		'{1'b1, RSP_FAST,    CH_CR},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b1, RSP_NONE,    CH_LF},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b0, RSP_NONE,    "9"},
		'{1'b1, RSP_DENIED,  CH_CR},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b0, RSP_NONE,    "1"},
		'{1'b0, RSP_NONE,    "2"},
		'{1'b0, RSP_NONE,    "3"},
		'{1'b0, RSP_NONE,    "4"},
		'{1'b0, RSP_NONE,    CH_L},
		'{1'b0, RSP_NONE,    "8"},
		'{1'b0, RSP_NONE,    CH_CARET},
		'{1'b1, RSP_LEFT,    CH_CR}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata = 8'h00;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  cfg_we = 1'b0;
	logic [15:0]           cfg_wdata = 16'h0000;

	// Parser state as the block should hold it.
	logic [15:0] pin_reg = PIN_RESET;
	pmode_t      pmode = PM_IDLE;
	logic [4:0]  cmd_len = '0;
	logic [7:0]  lead_char = '0;
	fphase_t     fphase = FP_PIN;
	logic [15:0] pin_acc = '0;
	logic [7:0]  cmd_letter = '0;
	logic [15:0] dur_acc = '0;
	logic        rate_fast = 1'b1;

	reply_t     reply_q [$];
	logic [7:0] byte_q [$];
	int         fail_cnt = 0;
	int         beats_sent = 0;
	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;

	caret_command_line_parser_top #(.CMD_LEN(CMD_LEN)) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic is_num(input logic [7:0] b);
		return (b >= CH_ZERO) && (b <= CH_NINE);
	endfunction

	function automatic logic [15:0] dec_shift(input logic [15:0] acc, input logic [7:0] b);
		logic [31:0] t;
		t = {16'd0, acc} * 32'd10 + {24'd0, b - CH_ZERO};
		return t[15:0];
	endfunction

	task automatic clear_cmd();
		cmd_len = '0;
		lead_char = '0;
		fphase = FP_PIN;
		pin_acc = '0;
		cmd_letter = '0;
		dur_acc = '0;
	endtask

	task automatic take_char(input logic [7:0] b);
		if (cmd_len == 0) begin
			lead_char = b;
		end
		// Only a command that opens with a digit is parsed into its fields.
		if (is_num(lead_char)) begin
			if (fphase == FP_PIN) begin
				if (is_num(b)) begin
					pin_acc = dec_shift(pin_acc, b);
				end else begin
					cmd_letter = b;
					fphase = FP_DUR;
				end
			end else if (fphase == FP_DUR) begin
				if (is_num(b)) begin
					dur_acc = dec_shift(dur_acc, b);
				end else begin
					fphase = FP_END;
				end
			end
		end
		cmd_len = cmd_len + 5'd1;
	endtask

	task automatic close_cmd(inout reply_t r);
		if (cmd_len == 1 && lead_char == CH_F) begin
			rate_fast = 1'b1;
			r.code = RSP_FAST;
		end else if (cmd_len == 1 && lead_char == CH_S) begin
			rate_fast = 1'b0;
			r.code = RSP_SLOW;
		end else if (cmd_len >= 1 && is_num(lead_char)) begin
			if (pin_acc != pin_reg) begin
				r.code = RSP_DENIED;
			end else begin
				case (cmd_letter)
					CH_F: r.code = RSP_FWD;
					CH_B: r.code = RSP_BACK;
					CH_L: r.code = RSP_LEFT;
					CH_R: r.code = RSP_RIGHT;
					default: r.code = RSP_UNKNOWN;
				endcase
				if (r.code != RSP_UNKNOWN) begin
					r.dur = dur_acc;
				end
			end
		end
		clear_cmd();
	endtask

	task automatic predict_reply(input logic [7:0] b, output reply_t r);
		logic eol;
		r = '0;
		r.echo = b;
		r.code = RSP_NONE;
		eol = (b == CH_CR) || (b == CH_LF);
		case (pmode)
			PM_IDLE: begin
				if (b == CH_CARET) begin
					clear_cmd();
					pmode = PM_WAIT;
				end else if (b != CH_DEL && b != CH_BS) begin
					r.fwd_v = 1'b1;
					r.fwd_b = b;
				end
			end
			PM_WAIT: begin
				if (b == CH_CARET) begin
					r.code = RSP_PRESENT;
					clear_cmd();
					pmode = PM_IDLE;
				end else if (eol) begin
					clear_cmd();
					pmode = PM_IDLE;
				end else begin
					take_char(b);
					pmode = PM_BUILD;
				end
			end
			default: begin
				if (eol) begin
					close_cmd(r);
					pmode = PM_IDLE;
				end else if (int'(cmd_len) < CMD_LEN - 1) begin
					take_char(b);
				end
			end
		endcase
		r.baud = rate_fast;
	endtask

	task automatic send_beat(input logic [7:0] b, input logic typed, input rsp_t code);
		reply_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready) begin
			@(posedge clk);
		end
		predict_reply(b, r);
		if (typed) begin
			r.code = code;
		end
		reply_q.push_back(r);
		beats_sent++;
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %h actual %h", $time, name, want, got);
			fail_cnt++;
		end
	endtask

	task automatic check_reply(input logic [OUT_DATA_W-1:0] d);
		reply_t want;
		if (reply_q.size() == 0) begin
			$display("%0t: result beat with nothing expected, expected none actual %h",
				$time, d);
			fail_cnt++;
		end else begin
			want = reply_q.pop_front();
			check_field("echo_byte", 16'(want.echo), 16'(d[7:0]));
			check_field("forward_valid", 16'(want.fwd_v), 16'(d[8]));
			check_field("forward_byte", 16'(want.fwd_b), 16'(d[16:9]));
			check_field("response_code", 16'(want.code), 16'(d[20:17]));
			check_field("duration", want.dur, d[36:21]);
			check_field("baud_fast", 16'(want.baud), 16'(d[37]));
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			check_reply(m_axis_tdata);
		end
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Any command character except line ends.
	function automatic logic [7:0] cmd_char();
		logic [7:0] b;
		b = 8'($urandom_range(255));
		while (b == CH_CR || b == CH_LF) begin
			b = 8'($urandom_range(255));
		end
		return b;
	endfunction

	function automatic logic [7:0] sep_char();
		logic [7:0] b;
		b = cmd_char();
		while (is_num(b)) begin
			b = cmd_char();
		end
		return b;
	endfunction

	function automatic logic [7:0] drive_letter();
		case ($urandom_range(3))
			0: return CH_F;
			1: return CH_B;
			2: return CH_L;
			default: return CH_R;
		endcase
	endfunction

	task automatic put_number(input int unsigned v);
		string s;
		s = $sformatf("%0d", v);
		for (int i = 0; i < s.len(); i++) begin
			byte_q.push_back(s[i]);
		end
	endtask

	task automatic make_sequence();
		int kind;
		int k;
		kind = $urandom_range(99);
		if (kind < 85) begin
			byte_q.push_back(CH_CARET);
		end
		if (kind < 45) begin
			// Robot command, mostly with the right PIN; a PIN plus 2^16 must wrap onto it.
			k = $urandom_range(9);
			if (k < 7) begin
				put_number(32'(pin_reg));
			end else if (k < 8) begin
				put_number({16'd0, pin_reg} + 32'd65536);
			end else begin
				put_number($urandom_range(99999));
			end
			k = $urandom_range(9);
			if (k != 0) begin
				byte_q.push_back(k == 1 ? sep_char() : drive_letter());
				if ($urandom_range(4) != 0) begin
					put_number($urandom_range(99999));
				end
				if ($urandom_range(4) == 0) begin
					repeat ($urandom_range(1, 4)) byte_q.push_back(cmd_char());
				end
			end
		end else if (kind < 55) begin
			byte_q.push_back(CH_CARET);
		end else if (kind < 65) begin
			byte_q.push_back($urandom_range(1) ? CH_F : CH_S);
			if ($urandom_range(3) == 0) begin
				byte_q.push_back(cmd_char());
			end
		end else if (kind < 70) begin
			// bare caret: the line end follows at once
		end else if (kind < 78) begin
			byte_q.push_back(8'(CH_ZERO + $urandom_range(9)));
			repeat ($urandom_range(28, 40)) begin
				byte_q.push_back($urandom_range(1) ? 8'(CH_ZERO + $urandom_range(9))
					: cmd_char());
			end
		end else if (kind < 85) begin
			repeat ($urandom_range(1, 8)) byte_q.push_back(cmd_char());
		end else begin
			repeat ($urandom_range(1, 8)) byte_q.push_back(8'($urandom_range(255)));
		end
		if (kind < 85) begin
			byte_q.push_back($urandom_range(1) ? CH_CR : CH_LF);
		end
	endtask

	task automatic run_phase(input int n_items, input int idle_pct, input int stall_pct);
		int stop_at;
		stop_at = beats_sent + n_items;
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		while (beats_sent < stop_at) begin
			make_sequence();
			while (byte_q.size() > 0) begin
				send_beat(byte_q.pop_front(), 1'b0, RSP_NONE);
			end
		end
		s_axis_tvalid <= 1'b0;
	endtask

	// The PIN is only written once every beat has drained out of the block.
	task automatic write_pin(input logic [15:0] v);
		wait (reply_q.size() == 0);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		pin_reg = v;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[i]) begin
			send_beat(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].code);
		end
		run_phase(380, 0, 0);
		write_pin(16'hFFFF);
		run_phase(380, 57, 0);
		write_pin(16'h0000);
		run_phase(380, 0, 57);
		write_pin(16'($urandom_range(65535)));
		run_phase(380, 35, 35);
		wait (reply_q.size() == 0);
		repeat (10) @(posedge clk);
		if (fail_cnt == 0) begin
			$display("caret_command_line_parser_top verification clean");
		end else begin
			$display("caret_command_line_parser_top verification failed");
		end
		$finish;
	end

	initial begin
		#3000000;
		$display("caret_command_line_parser_top verification failed");
		$finish;
	end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/cclp_pkg.sv
hw/rtl/cclp_parse.sv
hw/rtl/caret_command_line_parser_top.sv
hw/rtl/cclp_checker.sv
tb/tb_caret_command_line_parser_top.sv
